// ----- rtl/srsm_pkg.sv -----
// Package for the streaming regex matcher: command codes, pattern
// metacharacters and the structs passed between the top level and the cells.
// No dependencies.
`timescale 1ns / 1ps

package srsm_pkg;

  localparam int unsigned MaxElements = 32;

  typedef enum logic [1:0] {
    CmdClear   = 2'd0,
    CmdPattern = 2'd1,
    CmdText    = 2'd2,
    CmdEnd     = 2'd3
  } sr_cmd_e;

  localparam logic [7:0] CharCaret  = 8'h5E;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharDot    = 8'h2E;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic       append;
    logic       set_star;
    logic       step;
    logic       text_clear;
    logic       started;
    logic [7:0] data;
  } sr_ctl_t;

  // Signals handed from one cell to the next, for the position it owns.
  typedef struct packed {
    logic fwd;
    logic skip;
    logic init;
  } sr_link_t;

endpackage

// ----- rtl/srsm_cell.sv -----
// One pattern element and its NFA position bit for the regex matcher.
// Depends on srsm_pkg.
`timescale 1ns / 1ps

module srsm_cell #(
  parameter int unsigned MaxElements = srsm_pkg::MaxElements,
  parameter int unsigned Index       = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  srsm_pkg::sr_ctl_t                  ctl_i,
  input  logic [$clog2(MaxElements+1)-1:0]   count_i,
  input  logic [$clog2(MaxElements+1)-1:0]   len_i,
  input  srsm_pkg::sr_link_t                 link_i,
  output srsm_pkg::sr_link_t                 link_o,
  output logic                               cur_o,
  output logic                               closed_o
);

  localparam int unsigned CntW = $clog2(MaxElements + 1);

  logic [7:0] char_q;
  logic       star_q;
  logic       active_q;
  logic       active_d;
  logic       in_len;
  logic       cur;
  logic       hit;
  logic       closed;

  always_comb begin
    in_len = CntW'(Index) < len_i;
    cur    = ctl_i.started ? active_q : link_i.init;
    hit    = in_len && cur &&
             (char_q == srsm_pkg::CharDot || char_q == ctl_i.data);
    closed = link_i.fwd || (hit && star_q) || link_i.skip;

    link_o.init = link_i.init && star_q && in_len;
    link_o.fwd  = hit && !star_q;
    link_o.skip = closed && star_q && in_len;

    priority if (ctl_i.text_clear) begin
      active_d = 1'b0;
    end else if (ctl_i.step) begin
      active_d = closed;
    end else begin
      active_d = active_q;
    end
  end

  assign cur_o    = cur;
  assign closed_o = closed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.append && count_i == CntW'(Index)) begin
      char_q <= ctl_i.data;
      star_q <= 1'b0;
    end else if (ctl_i.set_star && count_i == CntW'(Index + 1)) begin
      star_q <= 1'b1;
    end
  end

endmodule

// ----- rtl/simple_regex_stream_matcher.sv -----
// Top level of the streaming regex matcher: pattern bookkeeping, the chain
// of element cells, the final accept position and the result register.
// Depends on srsm_pkg and srsm_cell.
//
//   Channel | Direction | Handshake                  | Payload
//   in      | input     | in_valid_i / in_stall_o    | cmd_i, byte_value_i
//   out     | output    | out_valid_o / out_stall_i  | matched_o, overflow_o
//
// One request is accepted per clock while in_stall_o is low.
// The critical path is the star-closure ripple through the cell chain.
// An end-of-text request shows its result in the next cycle from a register.
// A new request is accepted while a result waits, unless out_stall_i is high.
// Reset empties the pattern and the text; no clearing pass is needed.
`timescale 1ns / 1ps

module simple_regex_stream_matcher #(
  parameter int unsigned MaxElements = srsm_pkg::MaxElements
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] byte_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic       overflow_o
);

  localparam int unsigned CntW = $clog2(MaxElements + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            start_anchor_q, start_anchor_d;
  logic            first_q, first_d;
  logic            ovf_q, ovf_d;
  logic            last_star_q, last_star_d;
  logic            last_dollar_q, last_dollar_d;
  logic            end_q, end_d;
  logic            match_q, match_d;
  logic            started_q, started_d;
  logic            out_valid_q, out_valid_d;
  logic            res_match_q, res_match_d;
  logic            res_ovf_q, res_ovf_d;

  logic              accept;
  logic              anch;
  logic [CntW-1:0]   len;
  logic              match_eff;
  logic              hit;
  srsm_pkg::sr_cmd_e cmd;
  srsm_pkg::sr_ctl_t ctl;

  srsm_pkg::sr_link_t link [MaxElements:0];
  logic [MaxElements:0] cur_vec;
  logic [MaxElements:0] closed_vec;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd        = srsm_pkg::sr_cmd_e'(cmd_i);
  assign anch       = last_dollar_q && !last_star_q;
  assign len        = count_q - CntW'(anch);

  assign link[0].fwd  = !start_anchor_q;
  assign link[0].skip = 1'b0;
  assign link[0].init = 1'b1;

  for (genvar i = 0; i < MaxElements; i++) begin : g_cell
    srsm_cell #(
      .MaxElements(MaxElements),
      .Index      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .count_i (count_q),
      .len_i   (len),
      .link_i  (link[i]),
      .link_o  (link[i+1]),
      .cur_o   (cur_vec[i]),
      .closed_o(closed_vec[i])
    );
  end

  assign cur_vec[MaxElements]    = started_q ? end_q : link[MaxElements].init;
  assign closed_vec[MaxElements] = link[MaxElements].fwd || link[MaxElements].skip;

  assign match_eff = started_q ? match_q : (!anch && cur_vec[len]);
  assign hit       = started_q ? (match_q || (anch && cur_vec[len])) : cur_vec[len];

  always_comb begin
    count_d        = count_q;
    start_anchor_d = start_anchor_q;
    first_d        = first_q;
    ovf_d          = ovf_q;
    last_star_d    = last_star_q;
    last_dollar_d  = last_dollar_q;
    end_d          = end_q;
    match_d        = match_q;
    started_d      = started_q;
    res_match_d    = res_match_q;
    res_ovf_d      = res_ovf_q;
    out_valid_d    = out_valid_q && out_stall_i;
    ctl            = '0;
    ctl.data       = byte_value_i;
    ctl.started    = started_q;

    if (accept) begin
      unique case (cmd)
        srsm_pkg::CmdClear: begin
          count_d        = '0;
          start_anchor_d = 1'b0;
          first_d        = 1'b1;
          ovf_d          = 1'b0;
          last_star_d    = 1'b0;
          last_dollar_d  = 1'b0;
          ctl.text_clear = 1'b1;
          end_d          = 1'b0;
          match_d        = 1'b0;
          started_d      = 1'b0;
        end
        srsm_pkg::CmdPattern: begin
          first_d = 1'b0;
          priority if (first_q && byte_value_i == srsm_pkg::CharCaret) begin
            start_anchor_d = 1'b1;
          end else if (byte_value_i == srsm_pkg::CharStar && count_q != '0 &&
                       !last_star_q) begin
            ctl.set_star = 1'b1;
            last_star_d  = 1'b1;
          end else if (count_q == CntW'(MaxElements)) begin
            ovf_d = 1'b1;
          end else begin
            ctl.append    = 1'b1;
            count_d       = count_q + CntW'(1);
            last_star_d   = 1'b0;
            last_dollar_d = byte_value_i == srsm_pkg::CharDollar;
          end
        end
        srsm_pkg::CmdText: begin
          ctl.step  = 1'b1;
          started_d = 1'b1;
          end_d     = closed_vec[MaxElements];
          match_d   = match_eff || (!anch && closed_vec[len]);
        end
        srsm_pkg::CmdEnd: begin
          out_valid_d    = 1'b1;
          res_match_d    = hit && !ovf_q;
          res_ovf_d      = ovf_q;
          ctl.text_clear = 1'b1;
          end_d          = 1'b0;
          match_d        = 1'b0;
          started_d      = 1'b0;
        end
        default: begin
          ctl.text_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      start_anchor_q <= 1'b0;
      first_q        <= 1'b1;
      ovf_q          <= 1'b0;
      last_star_q    <= 1'b0;
      last_dollar_q  <= 1'b0;
      end_q          <= 1'b0;
      match_q        <= 1'b0;
      started_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      count_q        <= count_d;
      start_anchor_q <= start_anchor_d;
      first_q        <= first_d;
      ovf_q          <= ovf_d;
      last_star_q    <= last_star_d;
      last_dollar_q  <= last_dollar_d;
      end_q          <= end_d;
      match_q        <= match_d;
      started_q      <= started_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_match_q <= res_match_d;
    res_ovf_q   <= res_ovf_d;
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = res_match_q;
  assign overflow_o  = res_ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxElements))
    else $error("element count exceeds the store");

  a_anchor_needs_element: assert property (@(posedge clk_i) disable iff (!rst_ni)
    anch |-> count_q != '0)
    else $error("end anchor set with an empty pattern");

  a_overflow_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(matched_o && overflow_o))
    else $error("match reported together with overflow");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == srsm_pkg::CmdClear) |=> (count_q == '0 && !started_q && !ovf_q))
    else $error("clear request left pattern or text state behind");

  a_text_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == srsm_pkg::CmdText) |=> started_q)
    else $error("text byte did not start the text");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == srsm_pkg::CmdEnd) |=> (out_valid_o && !started_q && !match_q))
    else $error("end of text did not give a result or reset the text");

endmodule
